FILE: hdl/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types and codes for the ISO-TP multi-frame reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

  // PCI frame type nibbles
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // Payload bytes carried by each frame type
  localparam logic [2:0] FF_BYTES = 3'd6;
  localparam logic [2:0] CF_BYTES = 3'd7;

  // Number of byte slots in one job
  localparam int unsigned JOB_BYTES = 7;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FRAMES   = 3'd1,
    ST_BAD_FIRST   = 3'd2,
    ST_BAD_CONSEC  = 3'd3,
    ST_SEQ         = 3'd4,
    ST_INCOMPLETE  = 3'd5
  } status_t;

  // Assembly phase, one-hot
  typedef enum logic [2:0] {
    PH_WAIT    = 3'b001,
    PH_COLLECT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  // One job handed from the classifier to the emitter
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;   // payload bytes, first one in slot 0
    logic [2:0]                cnt;    // number of payload bytes, 0..7
    logic                      fin;    // set finishes with this job
    status_t                   status; // final status when fin
  } job_t;

endpackage

FILE: hdl/isotp_multiframe_reassembler_unit.sv
// ----------------------------------------------------------------------------
// isotp_multiframe_reassembler_unit
// ISO-TP multi-frame reassembler: frames in, payload bytes out.
// ----------------------------------------------------------------------------
// The first result of a frame passes the job queue and the output register.
// Throughput: the emitter issues one output beat per cycle while out_tready
// allows; a job gives a beat per payload byte (up to 7), or one if byteless.
// Resultless items push no job. A two-job queue decouples input from output.
// Reset: synchronous, active low; clears set state, queue and output valid.
// ----------------------------------------------------------------------------
module isotp_multiframe_reassembler_unit
  import isotp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // frame_byte0 .. frame_byte7
  input  logic        in_tlast,   // end_of_set
  input  logic        in_tuser,   // frame_present
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_byte[7:0], set_done[8], status[11:9]
  output logic        out_tlast,  // last_in_run
  output logic        out_tuser   // byte_valid
);

  logic q_full, q_push, q_pop, head_valid;
  job_t push_job, head_job;

  isotp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  isotp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  isotp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hdl/isotp_front.sv
// ----------------------------------------------------------------------------
// isotp_front
// Accepts frames, checks PCI type and sequence, tracks the set state and
// issues one job per item that produces results.
// ----------------------------------------------------------------------------
module isotp_front
  import isotp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  phase_t      phase_r, phase_nxt;
  logic [11:0] total_r, total_nxt;
  logic [11:0] emitted_r, emitted_nxt;
  logic [3:0]  seq_r, seq_nxt;

  logic [7:0][7:0] b;
  logic [11:0]     rem;
  logic [11:0]     ff_len;
  logic            accept;
  phase_t          ph_mid;
  job_t            job;

  assign b         = in_tdata;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ff_len    = {b[0][3:0], b[1]};
  assign rem       = total_r - emitted_r;

  // Classify the frame and work out the next state
  always_comb begin
    phase_nxt   = phase_r;
    total_nxt   = total_r;
    emitted_nxt = emitted_r;
    seq_nxt     = seq_r;
    job.data    = {b[7], b[6], b[5], b[4], b[3], b[2], b[1]};
    job.cnt     = '0;
    job.fin     = 1'b0;
    job.status  = ST_OK;

    if (in_tuser) begin
      case (phase_r)
        PH_WAIT: begin
          if (b[0][7:4] != PCI_FIRST) begin
            job.fin    = 1'b1;
            job.status = ST_BAD_FIRST;
            phase_nxt  = PH_DONE;
          end else begin
            // first frame: payload starts at byte 2
            job.data  = {8'h00, b[7], b[6], b[5], b[4], b[3], b[2]};
            total_nxt = ff_len;
            job.cnt   = (ff_len < {9'd0, FF_BYTES}) ? ff_len[2:0] : FF_BYTES;
            emitted_nxt = {9'd0, job.cnt};
            if (ff_len <= {9'd0, FF_BYTES}) begin
              job.fin   = 1'b1;
              job.status = ST_OK;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_COLLECT;
            end
          end
        end
        PH_COLLECT: begin
          if (b[0][7:4] != PCI_CONSEC) begin
            job.fin    = 1'b1;
            job.status = ST_BAD_CONSEC;
            phase_nxt  = PH_DONE;
          end else if (b[0][3:0] != seq_r) begin
            job.fin    = 1'b1;
            job.status = ST_SEQ;
            phase_nxt  = PH_DONE;
          end else begin
            job.cnt     = (rem < {9'd0, CF_BYTES}) ? rem[2:0] : CF_BYTES;
            emitted_nxt = emitted_r + {9'd0, job.cnt};
            seq_nxt     = seq_r + 4'd1;
            if (rem <= {9'd0, CF_BYTES}) begin
              job.fin   = 1'b1;
              job.status = ST_OK;
              phase_nxt = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end

    ph_mid = phase_nxt;

    // end of set: report a short set, then back to reset values
    if (in_tlast) begin
      if (ph_mid == PH_WAIT) begin
        job.fin    = 1'b1;
        job.status = ST_NO_FRAMES;
      end else if (ph_mid == PH_COLLECT) begin
        job.fin    = 1'b1;
        job.status = ST_INCOMPLETE;
      end
      phase_nxt   = PH_WAIT;
      total_nxt   = '0;
      emitted_nxt = '0;
      seq_nxt     = 4'd1;
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.cnt != 3'd0 || job.fin);

  // Set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      total_r   <= '0;
      emitted_r <= '0;
      seq_r     <= 4'd1;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      total_r   <= total_nxt;
      emitted_r <= emitted_nxt;
      seq_r     <= seq_nxt;
    end
  end

endmodule

FILE: hdl/isotp_fifo.sv
// ----------------------------------------------------------------------------
// isotp_fifo
// Two-entry job queue between classifier and emitter.
// ----------------------------------------------------------------------------
module isotp_fifo
  import isotp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue never written when full unless also read in the same cycle, nor read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("job queue underflow");

endmodule

FILE: hdl/isotp_back.sv
// ----------------------------------------------------------------------------
// isotp_back
// Emits the results of each job one per cycle, while out_tready allows, into an output register.
// ----------------------------------------------------------------------------
module isotp_back
  import isotp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, done_r, last_r;
  status_t    status_r;

  logic       load, has_bytes, last;
  logic [2:0] nres;

  assign has_bytes = (head_job.cnt != 3'd0);
  assign nres      = has_bytes ? head_job.cnt : 3'd1;
  assign last      = (idx_r == nres - 3'd1);
  assign load      = head_valid && (!out_valid_r || out_tready);
  assign pop       = load && last;
  assign idx_nxt   = last ? 3'd0 : idx_r + 3'd1;

  // Beat counter within the job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= has_bytes ? head_job.data[idx_r] : 8'h00;
      bvalid_r <= has_bytes;
      done_r   <= last && head_job.fin;
      status_r <= (last && head_job.fin) ? head_job.status : ST_OK;
      last_r   <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, status_r, done_r, byte_r};
  assign out_tlast  = last_r;
  assign out_tuser  = bvalid_r;

  // Result consistency
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r) else $error("set_done not on last beat");
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !bvalid_r) |-> (byte_r == 8'h00 && last_r && done_r))
    else $error("byteless beat malformed");
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> done_r)
    else $error("status without set_done");

endmodule
